// ----- hw/rtl/hsd_pkg.sv -----
`default_nettype none

package hsd_pkg;

   localparam int MAX_NODES_DEF = 255;
   localparam int LINK_W = 8;
   localparam int VAL_W = 7;
   localparam int LEN_W = 24;
   localparam logic [LINK_W-1:0] NO_LINK = 8'hFF;
   localparam logic [7:0] SIGN_MASK = 8'hFF;

   typedef struct packed {
      logic [7:0] sample_byte;
      logic       sample_done;
      logic       tree_error;
   } res_type;

   // Writes into the node tables. Value and left link go to the node being
   // built; the right link may go to an earlier node whose branch was pending.
   typedef struct packed {
      logic [LINK_W-1:0] addr;
      logic              val_we;
      logic [VAL_W-1:0]  val;
      logic              left_we;
      logic [LINK_W-1:0] left;
      logic              right_we;
      logic [LINK_W-1:0] right_addr;
      logic [LINK_W-1:0] right;
   } node_wr_type;

endpackage

`default_nettype wire

// ----- hw/rtl/hsd_node_mem.sv -----
`default_nettype none

module hsd_node_mem #(
   parameter int MAX_NODES = hsd_pkg::MAX_NODES_DEF
) (
   input  wire                           clock,
   input  wire hsd_pkg::node_wr_type     wr,
   input  wire                           rd_en,
   input  wire [hsd_pkg::LINK_W-1:0]     rd_addr,
   output logic [hsd_pkg::VAL_W-1:0]     val_q,
   output logic [hsd_pkg::LINK_W-1:0]    left_q,
   output logic [hsd_pkg::LINK_W-1:0]    right_q
);

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

   logic [hsd_pkg::VAL_W-1:0]  val_mem   [MAX_NODES];
   logic [hsd_pkg::LINK_W-1:0] left_mem  [MAX_NODES];
   logic [hsd_pkg::LINK_W-1:0] right_mem [MAX_NODES];

   always_ff @(posedge clock) begin
      if (wr.val_we) begin
         val_mem[wr.addr[AW-1:0]] <= wr.val;
      end
      if (wr.left_we) begin
         left_mem[wr.addr[AW-1:0]] <= wr.left;
      end
      if (wr.right_we) begin
         right_mem[wr.right_addr[AW-1:0]] <= wr.right;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         val_q   <= val_mem[rd_addr[AW-1:0]];
         left_q  <= left_mem[rd_addr[AW-1:0]];
         right_q <= right_mem[rd_addr[AW-1:0]];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/hsd_stack.sv -----
`default_nettype none

module hsd_stack #(
   parameter int MAX_NODES = hsd_pkg::MAX_NODES_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           clear,
   input  wire                           push,
   input  wire [hsd_pkg::LINK_W-1:0]     push_data,
   input  wire                           pop,
   output logic [hsd_pkg::LINK_W-1:0]    pop_q,
   output logic                          empty
);

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

   logic [hsd_pkg::LINK_W-1:0] stack_mem [MAX_NODES];
   logic [hsd_pkg::LINK_W-1:0] depth_ff;
   logic [hsd_pkg::LINK_W-1:0] depth_in;
   logic [hsd_pkg::LINK_W-1:0] top_addr;

   assign empty    = (depth_ff == '0);
   assign top_addr = depth_ff - 1'b1;

   always_comb begin
      depth_in = depth_ff;
      if (clear) begin
         depth_in = '0;
      end else if (push) begin
         depth_in = depth_ff + 1'b1;
      end else if (pop) begin
         depth_in = top_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[depth_ff[AW-1:0]] <= push_data;
      end
      if (pop) begin
         pop_q <= stack_mem[top_addr[AW-1:0]];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/hsd_out_buf.sv -----
`default_nettype none

module hsd_out_buf (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wire hsd_pkg::res_type res_in,
   input  wire                  flush,
   output logic                 room,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [7:0]           rsp_tdata,  // sample_byte
   output logic                 rsp_tlast,  // last_of_run
   output logic [1:0]           rsp_tuser   // [0] sample_done, [1] tree_error
);

   // The newest result waits in the hold stage until it is known whether
   // another result from the same request follows it.
   logic             hold_v_ff, hold_v_in;
   hsd_pkg::res_type hold_ff, hold_in;
   logic             out_v_ff, out_v_in;
   hsd_pkg::res_type out_ff, out_in;
   logic             last_ff, last_in;
   logic             out_free;
   logic             move;

   assign out_free = !out_v_ff || rsp_tready;
   assign room     = !hold_v_ff || out_free;
   assign move     = hold_v_ff && out_free && (push || flush);

   always_comb begin
      out_v_in  = out_v_ff && !rsp_tready;
      out_in    = out_ff;
      last_in   = last_ff;
      hold_v_in = hold_v_ff;
      hold_in   = hold_ff;
      if (move) begin
         out_v_in = 1'b1;
         out_in   = hold_ff;
         last_in  = flush;
      end
      if (push) begin
         hold_v_in = 1'b1;
         hold_in   = res_in;
      end else if (move) begin
         hold_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
      hold_ff <= hold_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff.sample_byte;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {out_ff.tree_error, out_ff.sample_done};

endmodule

`default_nettype wire

// ----- hw/rtl/tracker_huffman_sample_decoder.sv -----
`default_nettype none

// Each request carries eight stream bits, taken one at a time by a sequencer.
// A tree bit is handled in S_BIT, plus S_LINK when it closes a pending right branch; a
// decode bit takes a node-table read in S_BIT and an evaluation in S_EVAL, set by the single
// read port. A request is accepted in S_IDLE, closed in S_FLUSH and stalled while results wait;
// a request that ends the stream may stop early, and an ignored one is dropped in S_IDLE.
// Synchronous reset clears the control state; the node tables get no clearing pass.
module tracker_huffman_sample_decoder #(
   parameter int MAX_NODES = hsd_pkg::MAX_NODES_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire [7:0]                    req_tdata,  // compressed_byte
   input  wire                          req_tuser,  // first_byte
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [7:0]                   rsp_tdata,  // sample_byte
   output logic                         rsp_tlast,  // last_of_run
   output logic [1:0]                   rsp_tuser,  // [0] sample_done, [1] tree_error
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [hsd_pkg::LEN_W-1:0]     csr_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_BIT, S_LINK, S_EVAL, S_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      P_IDLE, P_TREE, P_DECODE, P_DONE
   } phase_type;

   localparam logic [1:0] SIGN_NONE = 2'd0;
   localparam logic [1:0] SIGN_POS  = 2'd1;
   localparam logic [1:0] SIGN_NEG  = 2'd2;
   localparam logic [3:0] LAST_FIELD_BIT = 4'd8;

   state_type                     st_ff, st_in;
   phase_type                     phase_ff, phase_in;
   logic [7:0]                    byte_ff, byte_in;
   logic [2:0]                    idx_ff, idx_in;
   logic [7:0]                    holder_ff, holder_in;
   logic [3:0]                    cnt_ff, cnt_in;
   logic [hsd_pkg::LINK_W-1:0]    node_count_ff, node_count_in;
   logic [1:0]                    sign_ff, sign_in;
   logic [hsd_pkg::LEN_W-1:0]     bytes_left_ff, bytes_left_in;
   logic [hsd_pkg::LEN_W-1:0]     sample_length_ff;

   hsd_pkg::node_wr_type          wr;
   logic                          rd_en;
   logic [hsd_pkg::LINK_W-1:0]    rd_addr;
   logic [hsd_pkg::VAL_W-1:0]     val_q;
   logic [hsd_pkg::LINK_W-1:0]    left_q;
   logic [hsd_pkg::LINK_W-1:0]    right_q;

   logic                          stk_clear;
   logic                          stk_push;
   logic                          stk_pop;
   logic [hsd_pkg::LINK_W-1:0]    stk_q;
   logic                          stk_empty;

   logic                          res_push;
   hsd_pkg::res_type              res;
   logic                          flush;
   logic                          ob_room;

   logic                          bit_cur;
   logic [hsd_pkg::LINK_W-1:0]    nc_next;
   logic                          advance;
   logic                          end_byte;

   assign req_tready = (st_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign bit_cur    = byte_ff[idx_ff];
   assign nc_next    = node_count_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_length_ff <= '0;
      end else if (csr_valid) begin
         sample_length_ff <= csr_data;
      end
   end

   always_comb begin
      st_in         = st_ff;
      phase_in      = phase_ff;
      byte_in       = byte_ff;
      idx_in        = idx_ff;
      holder_in     = holder_ff;
      cnt_in        = cnt_ff;
      node_count_in = node_count_ff;
      sign_in       = sign_ff;
      bytes_left_in = bytes_left_ff;
      wr            = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      stk_clear     = 1'b0;
      stk_push      = 1'b0;
      stk_pop       = 1'b0;
      res_push      = 1'b0;
      res           = '0;
      flush         = 1'b0;
      advance       = 1'b0;
      end_byte      = 1'b0;

      case (st_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               byte_in = req_tdata;
               idx_in  = '0;
               if (req_tuser) begin
                  phase_in      = P_TREE;
                  cnt_in        = '0;
                  node_count_in = '0;
                  sign_in       = SIGN_NONE;
                  bytes_left_in = sample_length_ff;
                  stk_clear     = 1'b1;
                  st_in         = S_BIT;
               end else if (phase_ff == P_TREE || phase_ff == P_DECODE) begin
                  st_in = S_BIT;
               end
            end
         end

         S_BIT: begin
            if (ob_room) begin
               case (phase_ff)
                  P_TREE: begin
                     if (cnt_ff != LAST_FIELD_BIT) begin
                        holder_in[cnt_ff[2:0]] = bit_cur;
                        cnt_in  = cnt_ff + 1'b1;
                        advance = 1'b1;
                     end else if (node_count_ff >= hsd_pkg::LINK_W'(MAX_NODES)) begin
                        res_push       = 1'b1;
                        res.tree_error = 1'b1;
                        phase_in       = P_DONE;
                        end_byte       = 1'b1;
                     end else begin
                        // Ninth bit: the node is complete; bit 7 is the left
                        // flag and the current bit is the right flag.
                        cnt_in        = '0;
                        wr.addr       = node_count_ff;
                        wr.val_we     = 1'b1;
                        wr.val        = holder_ff[6:0];
                        wr.left_we    = 1'b1;
                        wr.left       = holder_ff[7] ? nc_next : hsd_pkg::NO_LINK;
                        wr.right_addr = node_count_ff;
                        node_count_in = nc_next;
                        if (holder_ff[7]) begin
                           if (bit_cur) begin
                              stk_push = 1'b1;
                           end else begin
                              wr.right_we = 1'b1;
                              wr.right    = hsd_pkg::NO_LINK;
                           end
                           advance = 1'b1;
                        end else if (bit_cur) begin
                           wr.right_we = 1'b1;
                           wr.right    = nc_next;
                           advance     = 1'b1;
                        end else begin
                           wr.right_we = 1'b1;
                           wr.right    = hsd_pkg::NO_LINK;
                           if (!stk_empty) begin
                              stk_pop = 1'b1;
                              st_in   = S_LINK;
                           end else if (bytes_left_ff == '0) begin
                              phase_in = P_DONE;
                              end_byte = 1'b1;
                           end else begin
                              phase_in = P_DECODE;
                              sign_in  = SIGN_NONE;
                              advance  = 1'b1;
                           end
                        end
                     end
                  end
                  P_DECODE: begin
                     rd_en = 1'b1;
                     if (sign_ff == SIGN_NONE) begin
                        sign_in = bit_cur ? SIGN_NEG : SIGN_POS;
                        rd_addr = '0;
                     end else begin
                        rd_addr = bit_cur ? right_q : left_q;
                     end
                     st_in = S_EVAL;
                  end
                  default: begin
                     end_byte = 1'b1;
                  end
               endcase
            end
         end

         S_LINK: begin
            // The popped node's right child is the node that follows.
            wr.right_we   = 1'b1;
            wr.right_addr = stk_q;
            wr.right      = node_count_ff;
            advance       = 1'b1;
         end

         S_EVAL: begin
            if (ob_room) begin
               if (left_q == hsd_pkg::NO_LINK || right_q == hsd_pkg::NO_LINK) begin
                  res_push        = 1'b1;
                  res.sample_byte = {1'b0, val_q}
                                    ^ ((sign_ff == SIGN_NEG) ? hsd_pkg::SIGN_MASK : 8'h00);
                  res.sample_done = (bytes_left_ff == hsd_pkg::LEN_W'(1));
                  bytes_left_in   = bytes_left_ff - 1'b1;
                  sign_in         = SIGN_NONE;
                  if (bytes_left_ff == hsd_pkg::LEN_W'(1)) begin
                     phase_in = P_DONE;
                     end_byte = 1'b1;
                  end else begin
                     advance = 1'b1;
                  end
               end else begin
                  advance = 1'b1;
               end
            end
         end

         S_FLUSH: begin
            flush = 1'b1;
            if (ob_room) begin
               st_in = S_IDLE;
            end
         end

         default: begin
            st_in = S_IDLE;
         end
      endcase

      if (advance) begin
         if (idx_ff == 3'd7) begin
            end_byte = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
            st_in  = S_BIT;
         end
      end
      if (end_byte) begin
         st_in = S_FLUSH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= S_IDLE;
         phase_ff      <= P_IDLE;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         node_count_ff <= '0;
         sign_ff       <= SIGN_NONE;
         bytes_left_ff <= '0;
      end else begin
         st_ff         <= st_in;
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         node_count_ff <= node_count_in;
         sign_ff       <= sign_in;
         bytes_left_ff <= bytes_left_in;
      end
      byte_ff   <= byte_in;
      holder_ff <= holder_in;
   end

   hsd_node_mem #(
      .MAX_NODES (MAX_NODES)
   ) u_node_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .val_q   (val_q),
      .left_q  (left_q),
      .right_q (right_q)
   );

   hsd_stack #(
      .MAX_NODES (MAX_NODES)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .clear     (stk_clear),
      .push      (stk_push),
      .push_data (node_count_ff),
      .pop       (stk_pop),
      .pop_q     (stk_q),
      .empty     (stk_empty)
   );

   hsd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_push),
      .res_in     (res),
      .flush      (flush),
      .room       (ob_room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/hsd_checker.sv -----
`default_nettype none

module hsd_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_tvalid,
   input wire       rsp_tready,
   input wire [7:0] rsp_tdata,
   input wire       rsp_tlast,
   input wire [1:0] rsp_tuser
);

   // A tree error is reported alone, with a zero byte, and ends the request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && rsp_tdata == 8'h00)
      else $error("tree error result malformed");

   // The final sample byte discards the rest of its request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("sample done without last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("done and error together");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind tracker_huffman_sample_decoder hsd_checker u_hsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
